@@ design/odq_pkg.sv @@
package odq_pkg;

	localparam int CAPACITY = 16;
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = 32;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd1;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd2;
	localparam logic [2:0] MODE_POP_BACK   = 3'd3;
	localparam logic [2:0] MODE_INSERT     = 3'd4;
	localparam logic [2:0] MODE_REMOVE     = 3'd5;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [1:0] PH_FRONT = 2'd0;
	localparam logic [1:0] PH_BACK  = 2'd1;
	localparam logic [1:0] PH_SCAN  = 2'd2;

	typedef logic [DW-1:0] word_t;

endpackage

@@ design/odq_ram.sv @@
module odq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/ordered_deque_with_sorted_insert.sv @@
// channel | direction | handshake          | fields
// input   | in        | in_valid/in_ready   | mode[2:0], value[31:0] signed
// output  | out       | out_valid/out_ready | status[1:0], position[3:0], count[4:0]
//
// Entries sit in one RAM with a registered read; every access is sequenced. Flagged
// and unused-mode words go straight to done; push back and pop back pass through the
// finish state; shifts read, then write, each moved entry. Sorted insert and remove read
// front, back, then scan, reading and checking one entry at a time. A new word is taken
// once the previous one has left the sequencer; the result register lets it run while
// a result waits. Reset clears the count and control; entry contents are not cleared.
module ordered_deque_with_sorted_insert (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            mode,
	input  logic signed [31:0]    value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [3:0]            position,
	output logic [4:0]            count
);

	localparam int AW = odq_pkg::AW;
	localparam int CW = odq_pkg::CW;
	localparam logic [CW-1:0] CAP = CW'(odq_pkg::CAPACITY);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHK_RD = 3'd1;
	localparam logic [2:0] S_CHK_EV = 3'd2;
	localparam logic [2:0] S_MV_RD  = 3'd3;
	localparam logic [2:0] S_MV_WR  = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]      state_q;
	odq_pkg::word_t  val_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   pos_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   addr_q;
	logic [1:0]      phase_q;
	logic            ins_q;
	logic [1:0]      stat_q;
	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [3:0]      position_q;
	logic [4:0]      count_q;

	logic            we;
	logic [AW-1:0]   waddr;
	odq_pkg::word_t  wdata;
	logic [AW-1:0]   raddr;
	odq_pkg::word_t  rdata;
	logic            lt;
	logic            eq;
	logic [CW-1:0]   mv_src;

	assign lt = $signed(rdata) < $signed(val_q);
	assign eq = rdata == val_q;
	assign mv_src = ins_q ? (idx_q - CW'(1)) : (idx_q + CW'(1));

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = addr_q[AW-1:0];
		case (state_q)
			S_MV_RD: raddr = mv_src[AW-1:0];
			S_MV_WR: we = 1'b1;
			S_FIN: begin
				we    = ins_q;
				waddr = pos_q[AW-1:0];
				wdata = val_q;
			end
			default: ;
		endcase
	end

	odq_ram #(
		.WIDTH(odq_pkg::DW),
		.DEPTH(odq_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			idx_q       <= '0;
			addr_q      <= '0;
			phase_q     <= odq_pkg::PH_FRONT;
			ins_q       <= 1'b0;
			stat_q      <= odq_pkg::ST_DONE;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						val_q   <= value;
						phase_q <= odq_pkg::PH_FRONT;
						addr_q  <= '0;
						case (mode)
							odq_pkg::MODE_PUSH_FRONT, odq_pkg::MODE_PUSH_BACK,
							odq_pkg::MODE_INSERT: begin
								ins_q <= 1'b1;
								if (n_q >= CAP) begin
									stat_q  <= odq_pkg::ST_FULL;
									pos_q   <= '0;
									state_q <= S_DONE;
								end else if (mode == odq_pkg::MODE_INSERT && n_q != '0) begin
									stat_q  <= odq_pkg::ST_DONE;
									pos_q   <= '0;
									state_q <= S_CHK_RD;
								end else begin
									stat_q  <= odq_pkg::ST_DONE;
									pos_q   <= (mode == odq_pkg::MODE_PUSH_BACK) ? n_q : '0;
									idx_q   <= n_q;
									state_q <= (mode == odq_pkg::MODE_PUSH_BACK || n_q == '0)
										? S_FIN : S_MV_RD;
								end
							end
							odq_pkg::MODE_POP_FRONT, odq_pkg::MODE_POP_BACK,
							odq_pkg::MODE_REMOVE: begin
								ins_q <= 1'b0;
								if (n_q == '0) begin
									stat_q  <= odq_pkg::ST_EMPTY;
									pos_q   <= '0;
									state_q <= S_DONE;
								end else if (mode == odq_pkg::MODE_REMOVE) begin
									stat_q  <= odq_pkg::ST_DONE;
									pos_q   <= '0;
									state_q <= S_CHK_RD;
								end else if (mode == odq_pkg::MODE_POP_BACK) begin
									stat_q  <= odq_pkg::ST_DONE;
									pos_q   <= n_q - CW'(1);
									state_q <= S_FIN;
								end else begin
									stat_q  <= odq_pkg::ST_DONE;
									pos_q   <= '0;
									idx_q   <= '0;
									state_q <= (n_q > CW'(1)) ? S_MV_RD : S_FIN;
								end
							end
							default: begin
								stat_q  <= odq_pkg::ST_DONE;
								pos_q   <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_CHK_RD: state_q <= S_CHK_EV;
				S_CHK_EV: begin
					if (ins_q) begin
						case (phase_q)
							odq_pkg::PH_FRONT: begin
								if (!lt) begin
									pos_q   <= '0;
									idx_q   <= n_q;
									state_q <= S_MV_RD;
								end else begin
									phase_q <= odq_pkg::PH_BACK;
									addr_q  <= n_q - CW'(1);
									state_q <= S_CHK_RD;
								end
							end
							odq_pkg::PH_BACK: begin
								if (lt) begin
									pos_q   <= n_q;
									state_q <= S_FIN;
								end else begin
									phase_q <= odq_pkg::PH_SCAN;
									addr_q  <= '0;
									state_q <= S_CHK_RD;
								end
							end
							default: begin
								if (!lt || addr_q + CW'(1) == n_q) begin
									pos_q   <= lt ? n_q : addr_q;
									idx_q   <= n_q;
									state_q <= lt ? S_FIN : S_MV_RD;
								end else begin
									addr_q  <= addr_q + CW'(1);
									state_q <= S_CHK_RD;
								end
							end
						endcase
					end else begin
						case (phase_q)
							odq_pkg::PH_FRONT: begin
								if (eq) begin
									pos_q   <= '0;
									idx_q   <= '0;
									state_q <= (n_q > CW'(1)) ? S_MV_RD : S_FIN;
								end else begin
									phase_q <= odq_pkg::PH_BACK;
									addr_q  <= n_q - CW'(1);
									state_q <= S_CHK_RD;
								end
							end
							odq_pkg::PH_BACK: begin
								if (eq) begin
									pos_q   <= n_q - CW'(1);
									state_q <= S_FIN;
								end else begin
									phase_q <= odq_pkg::PH_SCAN;
									addr_q  <= '0;
									state_q <= S_CHK_RD;
								end
							end
							default: begin
								if (addr_q + CW'(1) < n_q && lt) begin
									addr_q  <= addr_q + CW'(1);
									state_q <= S_CHK_RD;
								end else if (eq) begin
									pos_q   <= addr_q;
									idx_q   <= addr_q;
									state_q <= (addr_q + CW'(1) < n_q) ? S_MV_RD : S_FIN;
								end else begin
									stat_q  <= odq_pkg::ST_NOTFOUND;
									state_q <= S_DONE;
								end
							end
						endcase
					end
				end
				S_MV_RD: state_q <= S_MV_WR;
				S_MV_WR: begin
					idx_q <= mv_src;
					if (ins_q) begin
						state_q <= (mv_src > pos_q) ? S_MV_RD : S_FIN;
					end else begin
						state_q <= (mv_src + CW'(1) < n_q) ? S_MV_RD : S_FIN;
					end
				end
				S_FIN: begin
					n_q     <= ins_q ? n_q + CW'(1) : n_q - CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			status_q   <= stat_q;
			position_q <= (stat_q == odq_pkg::ST_DONE) ? 4'(pos_q) : 4'd0;
			count_q    <= 5'(n_q);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) n_q <= CAP)
		else $error("count above capacity");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> ({1'b0, waddr} <= {1'b0, n_q}) && (n_q < CAP || !ins_q || state_q != S_FIN))
		else $error("write beyond fill");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !in_valid) |=> state_q == S_IDLE)
		else $error("left idle without a word");
	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(n_q) |-> $past(state_q) == S_FIN)
		else $error("count changed outside finish");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] position;
		logic [4:0] count;
	} outcome_t;

	typedef struct {
		logic [2:0] mode;
		logic [31:0] value;
		bit known;
		outcome_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] mode = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [3:0] position;
	logic [4:0] count;

	ordered_deque_with_sorted_insert DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic signed [31:0] held[$];
	outcome_t pending[$];
	int n_fail = 0;
	int n_words = 0;
	int n_results = 0;
	bit stimulus_done = 0;
	bit hold_off = 0;
	bit calm = 0;
	int quiet = 0;
	int mode_seen[8];

	function automatic outcome_t apply_op(logic [2:0] m, logic signed [31:0] v);
		outcome_t r;
		int n;
		int i;
		r = '0;
		n = held.size();
		case (m)
			odq_pkg::MODE_PUSH_FRONT: begin
				if (n >= odq_pkg::CAPACITY) r.status = odq_pkg::ST_FULL;
				else held.push_front(v);
			end
			odq_pkg::MODE_POP_FRONT: begin
				if (n == 0) r.status = odq_pkg::ST_EMPTY;
				else void'(held.pop_front());
			end
			odq_pkg::MODE_PUSH_BACK: begin
				if (n >= odq_pkg::CAPACITY) r.status = odq_pkg::ST_FULL;
				else begin
					r.position = 4'(n);
					held.push_back(v);
				end
			end
			odq_pkg::MODE_POP_BACK: begin
				if (n == 0) r.status = odq_pkg::ST_EMPTY;
				else begin
					r.position = 4'(n - 1);
					void'(held.pop_back());
				end
			end
			odq_pkg::MODE_INSERT: begin
				if (n >= odq_pkg::CAPACITY) r.status = odq_pkg::ST_FULL;
				else begin
					if (n == 0 || !(held[0] < v)) i = 0;
					else if (held[n-1] < v) i = n;
					else begin
						i = 0;
						while (i < n && held[i] < v) i++;
					end
					r.position = 4'(i);
					held.insert(i, v);
				end
			end
			odq_pkg::MODE_REMOVE: begin
				if (n == 0) r.status = odq_pkg::ST_EMPTY;
				else begin
					if (held[0] == v) i = 0;
					else if (held[n-1] == v) i = n - 1;
					else begin
						i = 0;
						while (i + 1 < n && held[i] < v) i++;
						if (held[i] != v) i = -1;
					end
					if (i < 0) r.status = odq_pkg::ST_NOTFOUND;
					else begin
						r.position = 4'(i);
						held.delete(i);
					end
				end
			end
			default: ;
		endcase
		r.count = 5'(held.size());
		return r;
	endfunction

	task automatic send(logic [2:0] m, logic signed [31:0] v, bit known = 0,
			outcome_t res = '0);
		outcome_t p;
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = apply_op(m, v);
		if (known && p != res) begin
			n_fail++;
			if (n_fail <= 10)
				$display("table row mismatch mode %0d: typed %p predicted %p", m, res, p);
		end
		pending.push_back(p);
		mode_seen[m]++;
		n_words++;
	endtask

	always @(posedge clk) begin
		if (!hold_off)
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
		else
			out_ready <= 1'b0;
		if (out_valid && out_ready) begin
			n_results++;
			if (pending.size() == 0) begin
				n_fail++;
				if (n_fail <= 10) $display("unexpected result %0d %0d %0d",
					status, position, count);
			end else begin
				if ({status, position, count} != pending[0]) begin
					n_fail++;
					if (n_fail <= 10)
						$display("mismatch: expected st %0d pos %0d cnt %0d, got %0d %0d %0d",
							pending[0].status, pending[0].position, pending[0].count,
							status, position, count);
				end
				void'(pending.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (arst_n && quiet > 20000) begin
			$display("timeout");
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return held.size() ? held[$urandom_range(held.size()-1)] : 0;
			3, 4, 5: return $signed($urandom_range(40)) - 20;
			default: return $urandom;
		endcase
	endfunction

	row_t table_rows[$];

	function automatic row_t mk(logic [2:0] m, logic [31:0] v, bit k = 0,
			logic [1:0] s = 0, logic [3:0] p = 0, logic [4:0] c = 0);
		row_t r;
		r.mode = m;
		r.value = v;
		r.known = k;
		r.res = '{s, p, c};
		return r;
	endfunction

	initial begin
		int i;
		int k;
		table_rows = '{
			mk(odq_pkg::MODE_POP_FRONT, 0, 1, odq_pkg::ST_EMPTY, 0, 0),
			mk(odq_pkg::MODE_POP_BACK, 0, 1, odq_pkg::ST_EMPTY, 0, 0),
			mk(odq_pkg::MODE_REMOVE, 5, 1, odq_pkg::ST_EMPTY, 0, 0),
			mk(odq_pkg::MODE_INSERT, 32'h8000_0000, 1, odq_pkg::ST_DONE, 0, 1),
			mk(odq_pkg::MODE_PUSH_BACK, 32'h7fff_ffff, 1, odq_pkg::ST_DONE, 1, 2),
			mk(odq_pkg::MODE_INSERT, 32'h8000_0000),
			mk(odq_pkg::MODE_INSERT, 32'h7fff_ffff),
			mk(odq_pkg::MODE_INSERT, 0),
			mk(odq_pkg::MODE_INSERT, 32'hffff_ffff),
			mk(odq_pkg::MODE_PUSH_FRONT, 7),
			mk(odq_pkg::MODE_REMOVE, 7),
			mk(odq_pkg::MODE_REMOVE, 32'h7fff_ffff),
			mk(odq_pkg::MODE_REMOVE, 0),
			mk(odq_pkg::MODE_REMOVE, 12345),
			mk(3'd6, 32'h5555_5555),
			mk(3'd7, 32'haaaa_aaaa),
			mk(odq_pkg::MODE_POP_FRONT, 0),
			mk(odq_pkg::MODE_POP_BACK, 0)
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[j])
			send(table_rows[j].mode, table_rows[j].value, table_rows[j].known,
				table_rows[j].res);
		while (held.size() < odq_pkg::CAPACITY) send(odq_pkg::MODE_INSERT, $urandom);
		send(odq_pkg::MODE_PUSH_FRONT, 1, 1,
			outcome_t'{odq_pkg::ST_FULL, 4'd0, 5'(odq_pkg::CAPACITY)});
		send(odq_pkg::MODE_PUSH_BACK, 1, 1,
			outcome_t'{odq_pkg::ST_FULL, 4'd0, 5'(odq_pkg::CAPACITY)});
		send(odq_pkg::MODE_INSERT, 1, 1,
			outcome_t'{odq_pkg::ST_FULL, 4'd0, 5'(odq_pkg::CAPACITY)});
		// drain by value
		while (held.size() > 0)
			send(odq_pkg::MODE_REMOVE, held[$urandom_range(held.size()-1)]);
		// hold off the receiver while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (k = 0; k < 40; k++) send(odq_pkg::MODE_INSERT, pick_value());
		join
		// pause until every result is in
		in_valid <= 1'b0;
		while (pending.size()) @(posedge clk);
		for (i = 0; i < 460; i++) begin
			calm = (i >= 200 && i < 280);
			k = $urandom_range(99);
			if (k < 35) send(odq_pkg::MODE_INSERT, pick_value());
			else if (k < 55) send(odq_pkg::MODE_REMOVE, pick_value());
			else if (k < 65) send(odq_pkg::MODE_PUSH_FRONT, pick_value());
			else if (k < 75) send(odq_pkg::MODE_PUSH_BACK, pick_value());
			else if (k < 85) send(odq_pkg::MODE_POP_FRONT, $urandom);
			else if (k < 96) send(odq_pkg::MODE_POP_BACK, $urandom);
			else send(3'($urandom_range(7)), $urandom);
		end
		calm = 0;
		in_valid <= 1'b0;
		while (pending.size()) @(posedge clk);
		repeat (4 * odq_pkg::CAPACITY + 20) @(posedge clk);
		$display("%0d words sent, %0d results checked; inserts %0d, removes %0d",
			n_words, n_results, mode_seen[odq_pkg::MODE_INSERT],
			mode_seen[odq_pkg::MODE_REMOVE]);
		if (n_fail == 0 && pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

@@ files.f @@
design/odq_pkg.sv
design/odq_ram.sv
design/ordered_deque_with_sorted_insert.sv
tb/sv/tb_top.sv
